[hdl/mbmt_pkg.sv]
// shared types, constants and arithmetic helpers for the backprop trainer
package mbmt_pkg;

  localparam int FRAC_BITS = 12;
  localparam int GAIN_FRAC = 12;
  localparam int WORD_BITS = 24;
  localparam int ACT_W     = 13;
  localparam int SUM_W     = 38;
  localparam int TERM_W    = 26;
  localparam int OSUM_W    = 30;
  localparam int MA_W      = 36;
  localparam int MB_W      = 25;
  localparam int P_W       = MA_W + MB_W;
  localparam int WIDE_W    = 40;
  localparam int ERR_W     = 14;
  localparam int GAIN_W    = 13;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] UPD_FIRST = 5'd14;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;
  localparam logic [ACT_W-1:0] ONE = 13'd4096;
  localparam logic [GAIN_W-1:0] LEARN_RATE_RST    = 13'd2048;
  localparam logic [GAIN_W-1:0] MOMENTUM_GAIN_RST = 13'd3686;

  // register indexes on the configuration channel
  localparam logic REG_LEARN_RATE    = 1'b0;
  localparam logic REG_MOMENTUM_GAIN = 1'b1;

  typedef enum logic [3:0] {
    L_NONE, L_MUL_A, L_ACC_A, L_ACC_B, L_SIG, L_MUL_HO, L_TERM, L_Q,
    L_BS, L_BD, L_DH, L_GRAD, L_ETA, L_ALPHA, L_WRITE
  } lane_op_t;

  typedef enum logic [2:0] {
    M_NONE, M_SUM, M_SIG, M_ERR, M_DO1, M_DO2, M_HSQ
  } merge_op_t;

  typedef struct packed {
    lane_op_t  lop;
    logic [1:0] slot;
    merge_op_t mop;
  } ctl_t;

  typedef struct packed {
    logic                        en;
    logic [3:0]                  index;
    logic signed [WORD_BITS-1:0] value;
  } load_t;

  // schedule of one training pass
  function automatic ctl_t step_ctl(input logic [STEP_W-1:0] step);
    ctl_t c;
    logic [STEP_W-1:0] u;
    c.lop  = L_NONE;
    c.slot = 2'd0;
    c.mop  = M_NONE;
    u      = step - UPD_FIRST;
    case (step)
      5'd0:  c.lop = L_MUL_A;
      5'd1:  c.lop = L_ACC_A;
      5'd2:  c.lop = L_ACC_B;
      5'd3:  c.lop = L_SIG;
      5'd4:  c.lop = L_MUL_HO;
      5'd5:  c.lop = L_TERM;
      5'd6:  begin c.lop = L_Q; c.mop = M_SUM; end
      5'd7:  c.mop = M_SIG;
      5'd8:  c.mop = M_ERR;
      5'd9:  c.mop = M_DO1;
      5'd10: c.mop = M_DO2;
      5'd11: begin c.lop = L_BS; c.mop = M_HSQ; end
      5'd12: c.lop = L_BD;
      5'd13: c.lop = L_DH;
      default: begin
        c.slot = u[3:2];
        case (u[1:0])
          2'd0:    c.lop = L_GRAD;
          2'd1:    c.lop = L_ETA;
          2'd2:    c.lop = L_ALPHA;
          default: c.lop = L_WRITE;
        endcase
      end
    endcase
    return c;
  endfunction

  // piecewise-linear sigmoid, result in Q1.12
  function automatic logic [ACT_W-1:0] sigmoid(input logic signed [SUM_W-1:0] x);
    logic [SUM_W:0]   a;
    logic [ACT_W-1:0] y;
    a = x[SUM_W-1] ? (SUM_W+1)'(-(SUM_W+1)'(x)) : (SUM_W+1)'(x);
    if (a >= 39'd20480)      y = ONE;
    else if (a >= 39'd9728)  y = 13'(a >> 5) + 13'd3456;
    else if (a >= 39'd4096)  y = 13'(a >> 3) + 13'd2560;
    else                     y = 13'(a >> 2) + 13'd2048;
    return x[SUM_W-1] ? ONE - y : y;
  endfunction

  // clip to the word, flag in the top bit
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((41'sd1 <<< (WORD_BITS-1)) - 41'sd1);
    lo = -WIDE_W'(41'sd1 <<< (WORD_BITS-1));
    if (v > hi)      return {1'b1, hi[WORD_BITS-1:0]};
    else if (v < lo) return {1'b1, lo[WORD_BITS-1:0]};
    else             return {1'b0, v[WORD_BITS-1:0]};
  endfunction

endpackage

[hdl/mbmt_lane.sv]
// one hidden unit: its three input weights, its output weight and momentum terms
module mbmt_lane import mbmt_pkg::*; #(
  parameter int HIDDEN_UNITS = 2,
  parameter int LANE_ID      = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctl_t                        ctl,
  input  load_t                       load,
  input  logic signed [WORD_BITS-1:0] xa,
  input  logic signed [WORD_BITS-1:0] xb,
  input  logic signed [ERR_W-1:0]     d_out,
  input  logic [GAIN_W-1:0]           eta,
  input  logic [GAIN_W-1:0]           alpha,
  output logic signed [TERM_W-1:0]    term,
  output logic                        clip
);

  localparam logic [5:0] BASE    = 6'(3 * LANE_ID);
  localparam logic [5:0] OUT_IDX = 6'(3 * HIDDEN_UNITS + 1 + LANE_ID);

  logic signed [WORD_BITS-1:0] w [4];
  logic signed [WORD_BITS-1:0] m [4];
  logic signed [P_W-1:0]       prod;
  logic signed [SUM_W-1:0]     acc;
  logic [ACT_W-1:0]            h;
  logic signed [WORD_BITS-1:0] q;
  logic signed [WORD_BITS-1:0] dh;
  logic signed [36:0]          t;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [WORD_BITS-1:0] s_bd;
  logic signed [WIDE_W-1:0]    chg;
  logic signed [WIDE_W-1:0]    wsum;
  logic [WORD_BITS:0]          m_sat;
  logic [WORD_BITS:0]          w_sat;
  logic [5:0]                  idx;

  assign idx  = {2'b00, load.index};
  assign s_bd = WORD_BITS'(prod >>> FRAC_BITS);

  // operand selection for the lane multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.lop)
      L_MUL_A:  begin mul_a = MA_W'(xa); mul_b = MB_W'(w[1]); end
      L_ACC_A:  begin mul_a = MA_W'(xb); mul_b = MB_W'(w[2]); end
      L_MUL_HO: begin mul_a = MA_W'({1'b0, h}); mul_b = MB_W'(w[3]); end
      L_TERM:   begin mul_a = MA_W'({1'b0, h}); mul_b = MB_W'({1'b0, ONE - h}); end
      L_BS:     begin mul_a = MA_W'(d_out); mul_b = MB_W'(w[3]); end
      L_BD:     begin mul_a = MA_W'(s_bd); mul_b = MB_W'(q); end
      L_GRAD: begin
        case (ctl.slot)
          2'd0:    mul_a = MA_W'({1'b0, ONE});
          2'd1:    mul_a = MA_W'(xa);
          2'd2:    mul_a = MA_W'(xb);
          default: mul_a = MA_W'({1'b0, h});
        endcase
        mul_b = (ctl.slot == 2'd3) ? MB_W'(d_out) : MB_W'(dh);
      end
      L_ETA:    begin mul_a = MA_W'(prod >>> GAIN_FRAC); mul_b = MB_W'({1'b0, eta}); end
      L_ALPHA:  begin mul_a = MA_W'(m[ctl.slot]); mul_b = MB_W'({1'b0, alpha}); end
      default:  ;
    endcase
  end

  // new change and new weight for the slot being updated
  always_comb begin
    chg   = WIDE_W'(t) + WIDE_W'(prod >>> GAIN_FRAC);
    m_sat = sat_word(chg);
    wsum  = WIDE_W'(w[ctl.slot]) + WIDE_W'($signed(m_sat[WORD_BITS-1:0]));
    w_sat = sat_word(wsum);
    clip  = (ctl.lop == L_WRITE) && (m_sat[WORD_BITS] || w_sat[WORD_BITS]);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (ctl.lop)
      L_ACC_A: acc  <= SUM_W'(w[0]) + SUM_W'(prod >>> FRAC_BITS);
      L_ACC_B: acc  <= acc + SUM_W'(prod >>> FRAC_BITS);
      L_SIG:   h    <= sigmoid(acc);
      L_TERM:  term <= TERM_W'(prod >>> FRAC_BITS);
      L_Q:     q    <= WORD_BITS'(prod);
      L_DH:    dh   <= WORD_BITS'(prod >>> (2 * FRAC_BITS));
      L_ALPHA: t    <= 37'(prod >>> GAIN_FRAC);
      default: ;
    endcase
  end

  // weights and momentum: loads and updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        w[k] <= '0;
        m[k] <= '0;
      end
    end else if (load.en) begin
      for (int k = 0; k < 3; k++) begin
        if (idx == BASE + 6'(k)) begin
          w[k] <= load.value;
          m[k] <= '0;
        end
      end
      if (idx == OUT_IDX) begin
        w[3] <= load.value;
        m[3] <= '0;
      end
    end else if (ctl.lop == L_WRITE) begin
      m[ctl.slot] <= m_sat[WORD_BITS-1:0];
      w[ctl.slot] <= w_sat[WORD_BITS-1:0];
    end
  end

endmodule

[hdl/mbmt_merge.sv]
// output unit: sums the lane terms, output sigmoid, error, half squared error, output delta, bias update
module mbmt_merge import mbmt_pkg::*; #(
  parameter int HIDDEN_UNITS = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctl_t                        ctl,
  input  load_t                       load,
  input  logic signed [TERM_W-1:0]    terms [HIDDEN_UNITS],
  input  logic [ACT_W-1:0]            tgt,
  input  logic [GAIN_W-1:0]           eta,
  input  logic [GAIN_W-1:0]           alpha,
  output logic [ACT_W-1:0]            o,
  output logic [11:0]                 half_sq,
  output logic signed [ERR_W-1:0]     d_out,
  output logic                        clip
);

  localparam logic [5:0] BIAS_IDX = 6'(3 * HIDDEN_UNITS);

  logic signed [WORD_BITS-1:0] wb;
  logic signed [WORD_BITS-1:0] mb;
  logic signed [P_W-1:0]       prod;
  logic signed [OSUM_W-1:0]    sum;
  logic signed [OSUM_W-1:0]    sum_next;
  logic signed [ERR_W-1:0]     err;
  logic signed [36:0]          t;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [WIDE_W-1:0]    chg;
  logic signed [WIDE_W-1:0]    wsum;
  logic [WORD_BITS:0]          m_sat;
  logic [WORD_BITS:0]          w_sat;
  logic                        upd;

  assign upd = (ctl.slot == 2'd0);

  // adder over the lane terms
  always_comb begin
    sum_next = OSUM_W'(wb);
    for (int j = 0; j < HIDDEN_UNITS; j++) sum_next = sum_next + OSUM_W'(terms[j]);
  end

  // operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mop)
      M_ERR: begin mul_a = MA_W'({1'b0, o}); mul_b = MB_W'({1'b0, ONE - o}); end
      M_DO1: begin mul_a = MA_W'(err); mul_b = MB_W'(prod); end
      M_DO2: begin mul_a = MA_W'(err); mul_b = MB_W'(err); end
      default: ;
    endcase
    if (upd) begin
      case (ctl.lop)
        L_GRAD:  begin mul_a = MA_W'({1'b0, ONE}); mul_b = MB_W'(d_out); end
        L_ETA:   begin mul_a = MA_W'(prod >>> GAIN_FRAC); mul_b = MB_W'({1'b0, eta}); end
        L_ALPHA: begin mul_a = MA_W'(mb); mul_b = MB_W'({1'b0, alpha}); end
        default: ;
      endcase
    end
  end

  // bias update arithmetic
  always_comb begin
    chg   = WIDE_W'(t) + WIDE_W'(prod >>> GAIN_FRAC);
    m_sat = sat_word(chg);
    wsum  = WIDE_W'(wb) + WIDE_W'($signed(m_sat[WORD_BITS-1:0]));
    w_sat = sat_word(wsum);
    clip  = upd && (ctl.lop == L_WRITE) && (m_sat[WORD_BITS] || w_sat[WORD_BITS]);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (ctl.mop)
      M_SUM: sum     <= sum_next;
      M_SIG: o       <= sigmoid(SUM_W'(sum));
      M_ERR: err     <= ERR_W'({1'b0, tgt}) - ERR_W'({1'b0, o});
      M_DO2: d_out   <= ERR_W'(prod >>> (2 * FRAC_BITS));
      M_HSQ: half_sq <= 12'(prod >>> (FRAC_BITS + 1));
      default: ;
    endcase
    if (upd && ctl.lop == L_ALPHA) t <= 37'(prod >>> GAIN_FRAC);
  end

  // output bias weight and its momentum
  always_ff @(posedge clk) begin
    if (rst) begin
      wb <= '0;
      mb <= '0;
    end else if (load.en) begin
      if ({2'b00, load.index} == BIAS_IDX) begin
        wb <= load.value;
        mb <= '0;
      end
    end else if (upd && ctl.lop == L_WRITE) begin
      mb <= m_sat[WORD_BITS-1:0];
      wb <= w_sat[WORD_BITS-1:0];
    end
  end

endmodule

[hdl/mlp_backprop_momentum_trainer.sv]
// top level: handshakes, configuration, sequencer and the hidden-unit lanes
// A load item writes one weight at its accepting edge; its acknowledge is then
// loaded into the result register from the done state, and the next item is taken
// only after that. A train item runs a 30-step schedule and then the done state
// loads the result register; a result register still held stalls the done state,
// and the next item is taken only after the result is loaded. The hidden
// units run in parallel lanes, each with one 36x25 multiplier that is reused
// step by step for the forward pass, the back-propagated delta and the four
// weight updates of its unit, while the merge unit forms the output, error and
// output delta with its own multiplier. Items are worked one at a time; the
// result register lets the next item in while a result still waits. No
// clearing pass after reset.
module mlp_backprop_momentum_trainer import mbmt_pkg::*; #(
  parameter int HIDDEN_UNITS = 2
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // weight_index, weight_value, input_a, input_b, target
  input  logic        s_tuser,  // kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // output_activation, half_sq_error, weight_saturated
  output logic        m_tuser,  // was_training
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                      state;
  logic [STEP_W-1:0]           step;
  logic [GAIN_W-1:0]           learn_rate;
  logic [GAIN_W-1:0]           momentum_gain;
  logic signed [WORD_BITS-1:0] xa;
  logic signed [WORD_BITS-1:0] xb;
  logic [ACT_W-1:0]            tgt;
  logic [ACT_W-1:0]            tgt_in;
  logic                        is_train;
  logic                        clip_acc;
  logic                        s_acc;
  ctl_t                        ctl;
  load_t                       load;
  logic signed [TERM_W-1:0]    terms [HIDDEN_UNITS];
  logic [HIDDEN_UNITS-1:0]     lane_clip;
  logic [ACT_W-1:0]            o;
  logic [11:0]                 half_sq;
  logic signed [ERR_W-1:0]     d_out;
  logic                        merge_clip;

  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign tgt_in    = (s_tdata[88:76] > ONE) ? ONE : s_tdata[88:76];

  // sequencer control word
  always_comb begin
    ctl = step_ctl(step);
    if (state != S_RUN) begin
      ctl.lop = L_NONE;
      ctl.mop = M_NONE;
    end
  end

  assign load.en    = s_acc && !s_tuser;
  assign load.index = s_tdata[3:0];
  assign load.value = $signed(s_tdata[27:4]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate    <= LEARN_RATE_RST;
      momentum_gain <= MOMENTUM_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEARN_RATE:    learn_rate    <= cfg_data;
        REG_MOMENTUM_GAIN: momentum_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // pattern capture
  always_ff @(posedge clk) begin
    if (s_acc) begin
      xa  <= $signed(s_tdata[51:28]);
      xb  <= $signed(s_tdata[75:52]);
      tgt <= tgt_in;
    end
  end

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      is_train <= 1'b0;
      clip_acc <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            is_train <= s_tuser;
            clip_acc <= 1'b0;
            step     <= '0;
            state    <= s_tuser ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          clip_acc <= clip_acc || merge_clip || (|lane_clip);
          step     <= step + 1'b1;
          if (step == LAST_STEP) state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tuser <= is_train;
      m_tdata <= {6'd0, clip_acc,
                  is_train ? half_sq : 12'd0,
                  is_train ? o : {ACT_W{1'b0}}};
    end
  end

  // hidden-unit lanes
  for (genvar j = 0; j < HIDDEN_UNITS; j++) begin : g_lane
    mbmt_lane #(.HIDDEN_UNITS(HIDDEN_UNITS), .LANE_ID(j)) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .load  (load),
      .xa    (xa),
      .xb    (xb),
      .d_out (d_out),
      .eta   (learn_rate),
      .alpha (momentum_gain),
      .term  (terms[j]),
      .clip  (lane_clip[j])
    );
  end

  mbmt_merge #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .load    (load),
    .terms   (terms),
    .tgt     (tgt),
    .eta     (learn_rate),
    .alpha   (momentum_gain),
    .o       (o),
    .half_sq (half_sq),
    .d_out   (d_out),
    .clip    (merge_clip)
  );

  // an accepted item always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> state != S_IDLE) else $error("accepted item did not start");

  // the step counter never runs past the schedule
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step <= LAST_STEP) else $error("step out of range");

  // load acknowledges carry no activation and no error
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[24:0] == 25'd0) else $error("load result not zero");

endmodule
